[src/bklf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the bracket keyword line filter.
// No dependencies; every other file imports this package.
package bklf_pkg;

    localparam int KW_SLOTS    = 4;   // keyword compare slots built
    localparam int KW_BYTES    = 8;   // longest keyword
    localparam int OFFSET_BITS = 48;  // offset and total counter width

    localparam int REG_SLOTS   = 4;   // keyword registers in the register map
    localparam int KW_USED     = (KW_SLOTS < REG_SLOTS) ? KW_SLOTS : REG_SLOTS;
    localparam int WIN_DEPTH   = KW_BYTES + 1;
    localparam int LEN_BITS    = $clog2(WIN_DEPTH);
    localparam int FIELD_BITS  = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 64;
    localparam int CNT_BITS    = 3;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = Q_PTR_BITS + 1;

    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;

    localparam logic [15:0]        LENS_RESET  = 16'h1111;
    localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KW0   = 3'd0,
        CFG_KW1   = 3'd1,
        CFG_KW2   = 3'd2,
        CFG_KW3   = 3'd3,
        CFG_LENS  = 3'd4,
        CFG_COUNT = 3'd5
    } t_cfg_idx;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [FIELD_BITS-1:0]  t_field;
    typedef logic [LEN_BITS-1:0]    t_len;

    // One matched line waiting for its report
    typedef struct packed {
        t_off first_off;
        t_off last_off;
    } t_line_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_field to_field(input t_off v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

[src/bklf_ifs.sv]
`timescale 1ns / 1ps
// Handshake channels of the filter: byte input, config write, line report.
// Depends on bklf_pkg.
interface bklf_byte_if import bklf_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_data;

    modport source (output valid, text_byte, end_of_data, input ready);
    modport sink   (input valid, text_byte, end_of_data, output ready);
endinterface

interface bklf_cfg_if import bklf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_DAT_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface bklf_rpt_if import bklf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field line_start;
    t_field line_end;
    t_field match_total;

    modport source (output valid, line_start, line_end, match_total, input ready);
    modport sink   (input valid, line_start, line_end, match_total, output ready);
endinterface

[src/bracket_keyword_line_filter_core.sv]
`timescale 1ns / 1ps
// Top level of the bracket keyword line filter: front end, line queue, back end.
// Depends on bklf_pkg, bklf_ifs, bklf_front, bklf_queue, bklf_back.
//
//  Port    Dir   Carries                                  Taken when
//  i_byte  in    text_byte[8], end_of_data[1]             valid && ready
//  i_cfg   in    index[3], data[64]                       valid (ready tied high)
//  o_rpt   out   line_start, line_end, match_total [48]   valid && ready
//
// One byte per cycle; i_byte.ready drops only while the 4-entry line queue is full.
// The report of a line is written into the line queue, then loaded into the back end's output register for o_rpt.
// A stalled o_rpt holds its report; lines queue behind it while bytes keep flowing until the queue is full.
// Synchronous active-low reset clears config to defaults, window, offsets and total.
module bracket_keyword_line_filter_core import bklf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bklf_byte_if.sink  i_byte,
    bklf_cfg_if.sink   i_cfg,
    bklf_rpt_if.source o_rpt
);

    t_q_stat   w_q_stat;
    logic      w_push;
    logic      w_pop;
    t_line_rec w_push_rec;
    t_line_rec w_pop_rec;

    bklf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (i_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    bklf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec),
        .o_stat  (w_q_stat)
    );

    bklf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_rec    (w_pop_rec),
        .o_pop    (w_pop),
        .o_rpt    (o_rpt)
    );

endmodule

[src/bklf_front.sv]
`timescale 1ns / 1ps
// Front end: config registers, byte window, keyword compare, line tracking.
// Depends on bklf_pkg and bklf_ifs; pushes matched lines into bklf_queue.
module bklf_front import bklf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bklf_byte_if.sink   i_byte,
    bklf_cfg_if.sink    i_cfg,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_line_rec   o_rec
);

    logic [REG_SLOTS-1:0][CFG_DAT_BITS-1:0] r_kw;
    logic [15:0]                            r_lens;
    logic [CNT_BITS-1:0]                    r_count;

    logic [WIN_DEPTH-1:0][7:0] r_win;
    logic [WIN_DEPTH-1:0][7:0] n_win;
    t_off                      r_off;
    t_off                      r_line_start;
    logic                      r_matched;

    logic [KW_USED-1:0][WIN_DEPTH-1:0] w_hit;
    logic [KW_USED-1:0]                w_slot_hit;
    logic                              w_any_hit;
    logic                              w_acc;
    logic                              w_line_end;
    logic                              w_matched;
    t_off                              w_off_inc;

    assign i_byte.ready = !i_q_stat.full;
    assign i_cfg.ready  = 1'b1;
    assign w_acc        = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw    <= '0;
            r_lens  <= LENS_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KW0:   r_kw[0] <= i_cfg.data;
                CFG_KW1:   r_kw[1] <= i_cfg.data;
                CFG_KW2:   r_kw[2] <= i_cfg.data;
                CFG_KW3:   r_kw[3] <= i_cfg.data;
                CFG_LENS:  r_lens  <= i_cfg.data[15:0];
                CFG_COUNT: r_count <= i_cfg.data[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window after this byte: slot zero is the newest byte
    always_comb begin
        n_win[0] = i_byte.text_byte;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Every possible length per slot is compared, then the configured one is picked
    always_comb begin
        for (int k = 0; k < KW_USED; k++) begin
            for (int l = 0; l < WIN_DEPTH; l++) begin
                w_hit[k][l] = (n_win[l] == BYTE_LBRACKET);
                for (int m = 0; m < l; m++) begin
                    w_hit[k][l] = w_hit[k][l] && (n_win[l-1-m] == r_kw[k][8*m +: 8]);
                end
            end
        end
    end

    always_comb begin
        logic [3:0] nib;
        t_len       len;
        for (int k = 0; k < KW_USED; k++) begin
            nib = r_lens[4*k +: 4];
            len = (32'(nib) > KW_BYTES) ? t_len'(KW_BYTES) : t_len'(nib);
            w_slot_hit[k] = w_hit[k][len] && (CNT_BITS'(k) < r_count);
        end
    end

    assign w_any_hit  = |w_slot_hit;
    assign w_line_end = (i_byte.text_byte == BYTE_NEWLINE) || i_byte.end_of_data;
    assign w_matched  = r_matched || w_any_hit;
    assign w_off_inc  = r_off + t_off'(1);

    assign o_push          = w_acc && w_line_end && w_matched;
    assign o_rec.first_off = r_line_start;
    assign o_rec.last_off  = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_off        <= '0;
            r_line_start <= '0;
            r_matched    <= 1'b0;
        end else if (w_acc) begin
            r_win <= i_byte.end_of_data ? '0 : n_win;
            r_off <= w_off_inc;
            if (w_line_end) begin
                r_matched    <= 1'b0;
                r_line_start <= w_off_inc;
            end else begin
                r_matched <= w_matched;
            end
        end
    end

`ifndef SYNTHESIS
    a_eod_clears_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_byte.end_of_data) |=> (r_win == '0 && !r_matched))
        else $error("window or line flag not cleared after end of data");
`endif

endmodule

[src/bklf_queue.sv]
`timescale 1ns / 1ps
// Short register queue of matched lines between front and back end.
// Depends on bklf_pkg.
module bklf_queue import bklf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_line_rec i_rec,
    input  logic      i_pop,
    output t_line_rec o_rec,
    output t_q_stat   o_stat
);

    t_line_rec                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]    r_wr_ptr;
    logic [Q_PTR_BITS-1:0]    r_rd_ptr;
    logic [Q_CNT_BITS-1:0]    r_cnt;

    assign o_stat.full  = (r_cnt == Q_CNT_BITS'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rec        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_BITS'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

[src/bklf_back.sv]
`timescale 1ns / 1ps
// Back end: match total counter and registered report output.
// Depends on bklf_pkg and bklf_ifs; drains bklf_queue.
module bklf_back import bklf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_line_rec   i_rec,
    output logic        o_pop,
    bklf_rpt_if.source  o_rpt
);

    logic      r_valid;
    t_line_rec r_rec;
    t_off      r_total;

    // Load a new report when the output stage is empty or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || o_rpt.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_total <= r_total + t_off'(1);
            end else if (o_rpt.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    assign o_rpt.valid       = r_valid;
    assign o_rpt.line_start  = to_field(r_rec.first_off);
    assign o_rpt.line_end    = to_field(r_rec.last_off);
    assign o_rpt.match_total = to_field(r_total);

`ifndef SYNTHESIS
    a_total_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_total == $past(r_total) + t_off'(1)) && r_valid)
        else $error("match total did not advance with a loaded report");
`endif

endmodule
